// ----- sv/pulse_period_duty_meter_macros.svh -----
// assertion macros used by the pulse meter checker
`ifndef PULSE_PERIOD_DUTY_METER_MACROS_SVH
`define PULSE_PERIOD_DUTY_METER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PPDM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PPDM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ppdm_pkg.sv -----
// shared types and constants of the pulse period and duty meter
package ppdm_pkg;

    // default timer and overflow counter widths
    localparam int TIMER_BITS_DEF    = 16;
    localparam int OVERFLOW_BITS_DEF = 8;

    // field widths
    localparam int XTAL_W = 7;
    localparam int PRE_W  = 4;
    localparam int FREQ_W = 24;
    localparam int DUTY_W = 7;

    // xtal_mhz * 1e6 stays below 2^27
    localparam int NUM_W      = 27;
    localparam int HZ_PER_MHZ = 1000000;

    // the timer ticks at a quarter of the oscillator frequency
    localparam int CLOCKS_SHIFT = 2;

    localparam logic [DUTY_W-1:0] PERCENT_FULL = 7'd100;
    localparam logic [FREQ_W-1:0] FREQ_MAX     = 24'hFFFFFF;

    // divider step counts for the two quotients
    localparam int FREQ_ITER = NUM_W;
    localparam int DUTY_ITER = DUTY_W;

    // configuration register reset values
    localparam logic [XTAL_W-1:0] XTAL_RESET = 7'd8;
    localparam logic [PRE_W-1:0]  PRE_RESET  = 4'd1;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_XTAL      = 1'b0;
    localparam logic REG_PRESCALER = 1'b1;

    // input operation codes
    localparam logic OP_OVERFLOW = 1'b0;
    localparam logic OP_CAPTURE  = 1'b1;

    // commands from the controller to the datapath and output stage
    typedef struct packed {
        logic mul_load;
        logic freq_load;
        logic duty_load;
        logic div_step;
        logic out_load;
    } ppdm_cmd_t;

endpackage

// ----- sv/ppdm_div.sv -----
// restoring divider, one quotient bit per step
module ppdm_div #(
    parameter int DIV_W = 30
) (
    input  logic                      aclk,
    input  logic                      load,
    input  logic                      step,
    input  logic [DIV_W-1:0]          rem_init,
    input  logic [ppdm_pkg::NUM_W-1:0] dividend,
    input  logic [DIV_W-1:0]          divisor,
    output logic [ppdm_pkg::NUM_W-1:0] quotient
);
    import ppdm_pkg::*;

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;

    // shift in the next dividend bit and try a subtract
    always_comb begin
        trial    = {rem_reg, dsh_reg[NUM_W-1]};
        diff     = trial - {1'b0, div_reg};
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        div_next = div_reg;
        quo_next = quo_reg;
        if (load) begin
            rem_next = rem_init;
            dsh_next = dividend;
            div_next = divisor;
            quo_next = '0;
        end else if (step) begin
            dsh_next = {dsh_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;

endmodule

// ----- sv/ppdm_dp.sv -----
// datapath: capture state, period arithmetic and the shared divider
module ppdm_dp #(
    parameter int TIMER_BITS    = ppdm_pkg::TIMER_BITS_DEF,
    parameter int OVERFLOW_BITS = ppdm_pkg::OVERFLOW_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic                        operation,
    input  logic [TIMER_BITS-1:0]       captured_count,
    input  logic [ppdm_pkg::XTAL_W-1:0] xtal_mhz,
    input  logic [ppdm_pkg::PRE_W-1:0]  timer_prescaler,
    input  ppdm_pkg::ppdm_cmd_t         cmd,
    output logic                        need_calc,
    output logic [ppdm_pkg::FREQ_W-1:0] frequency_hz,
    output logic [ppdm_pkg::DUTY_W-1:0] duty_percent,
    output logic                        zero_period
);
    import ppdm_pkg::*;

    localparam int SPAN_W = TIMER_BITS + OVERFLOW_BITS;
    localparam int DEN_W  = SPAN_W + PRE_W + CLOCKS_SHIFT;
    localparam int HUND_W = SPAN_W + DUTY_W;

    // capture phases
    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_FALL  = 2'd1;
    localparam logic [1:0] PH_THIRD = 2'd2;

    logic [1:0]               phase_reg, phase_next;
    logic [OVERFLOW_BITS-1:0] ovf_reg, ovf_next;
    logic [TIMER_BITS-1:0]    first_reg, first_next;
    logic [SPAN_W-1:0]        fall_reg, fall_next;
    logic [SPAN_W-1:0]        period_reg, period_next;
    logic [SPAN_W-1:0]        high_reg, high_next;
    logic [NUM_W-1:0]         numer_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [HUND_W-1:0]        hund_reg;
    logic                     zero_reg;
    logic                     clamp_reg;
    logic [NUM_W-1:0]         freq_q_reg;
    logic [SPAN_W-1:0]        ext_time;
    logic [SPAN_W-1:0]        first_ext;
    logic [PRE_W-1:0]         pre_eff;
    logic                     div_load;
    logic [DEN_W-1:0]         div_rem_init;
    logic [NUM_W-1:0]         div_dividend;
    logic [DEN_W-1:0]         div_divisor;
    logic [NUM_W-1:0]         quotient;

    assign ext_time  = {ovf_reg, captured_count};
    assign first_ext = {{OVERFLOW_BITS{1'b0}}, first_reg};
    assign need_calc = (operation == OP_CAPTURE) && (phase_reg == PH_THIRD);

    // event handling: overflow counting and the three capture phases
    always_comb begin
        phase_next  = phase_reg;
        ovf_next    = ovf_reg;
        first_next  = first_reg;
        fall_next   = fall_reg;
        period_next = period_reg;
        high_next   = high_reg;
        if (accept) begin
            if (operation == OP_OVERFLOW) begin
                ovf_next = ovf_reg + 1'b1;
            end else begin
                case (phase_reg)
                    PH_FALL: begin
                        fall_next  = ext_time;
                        phase_next = PH_THIRD;
                    end
                    PH_THIRD: begin
                        period_next = ext_time - first_ext;
                        high_next   = fall_reg - first_ext;
                        phase_next  = PH_FIRST;
                    end
                    default: begin
                        ovf_next   = '0;
                        first_next = captured_count;
                        phase_next = PH_FALL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            ovf_reg   <= '0;
            first_reg <= '0;
            fall_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            ovf_reg   <= ovf_next;
            first_reg <= first_next;
            fall_reg  <= fall_next;
        end
    end

    assign pre_eff = (timer_prescaler == '0) ? PRE_W'(1) : timer_prescaler;

    // period and high time, then the scaled operands
    always_ff @(posedge aclk) begin
        period_reg <= period_next;
        high_reg   <= high_next;
        if (cmd.mul_load) begin
            numer_reg <= NUM_W'(xtal_mhz) * NUM_W'(HZ_PER_MHZ);
            den_reg   <= (DEN_W'(pre_eff) * DEN_W'(period_reg)) << CLOCKS_SHIFT;
            hund_reg  <= HUND_W'(high_reg) * HUND_W'(PERCENT_FULL);
            zero_reg  <= (period_reg == '0);
            clamp_reg <= (high_reg >= period_reg);
        end
        if (cmd.duty_load) begin
            freq_q_reg <= quotient;
        end
    end

    // divider operand select: frequency first, then duty
    always_comb begin
        div_load = cmd.freq_load || cmd.duty_load;
        if (cmd.duty_load) begin
            div_rem_init = {{(DEN_W-SPAN_W){1'b0}}, hund_reg[HUND_W-1:DUTY_ITER]};
            div_dividend = {hund_reg[DUTY_ITER-1:0], {(NUM_W-DUTY_ITER){1'b0}}};
            div_divisor  = {{(DEN_W-SPAN_W){1'b0}}, period_reg};
        end else begin
            div_rem_init = '0;
            div_dividend = numer_reg;
            div_divisor  = den_reg;
        end
    end

    ppdm_div #(
        .DIV_W(DEN_W)
    ) u_div (
        .aclk     (aclk),
        .load     (div_load),
        .step     (cmd.div_step),
        .rem_init (div_rem_init),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient)
    );

    // result with saturation, clamping and the zero period case
    always_comb begin
        zero_period = zero_reg;
        if (zero_reg) begin
            frequency_hz = '0;
            duty_percent = '0;
        end else begin
            if (|freq_q_reg[NUM_W-1:FREQ_W]) begin
                frequency_hz = FREQ_MAX;
            end else begin
                frequency_hz = freq_q_reg[FREQ_W-1:0];
            end
            if (clamp_reg) begin
                duty_percent = PERCENT_FULL;
            end else begin
                duty_percent = quotient[DUTY_W-1:0];
            end
        end
    end

endmodule

// ----- sv/ppdm_ctrl.sv -----
// controller: sequences the multiply, the two divisions and the result load
module ppdm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                need_calc,
    input  logic                out_free,
    output logic                in_ready,
    output ppdm_pkg::ppdm_cmd_t cmd
);
    import ppdm_pkg::*;

    localparam int CNT_W = $clog2(FREQ_ITER);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_FLOAD = 3'd2;
    localparam logic [2:0] S_FDIV  = 3'd3;
    localparam logic [2:0] S_DLOAD = 3'd4;
    localparam logic [2:0] S_DDIV  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept && need_calc) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_load = 1'b1;
                state_next   = S_FLOAD;
            end
            S_FLOAD: begin
                cmd.freq_load = 1'b1;
                cnt_next      = CNT_W'(FREQ_ITER - 1);
                state_next    = S_FDIV;
            end
            S_FDIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_DLOAD;
                end
            end
            S_DLOAD: begin
                cmd.duty_load = 1'b1;
                cnt_next      = CNT_W'(DUTY_ITER - 1);
                state_next    = S_DDIV;
            end
            S_DDIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ----- sv/pulse_period_duty_meter.sv -----
// Overflows and first or second captures keep s_ready high: input goes on next cycle.
// Third capture: s_ready drops while the controller runs the multiply, the shared restoring
// divider (27 frequency steps, 7 duty steps, one bit a step) and the result load.
// A result waiting on the output register holds back the next result, and input with it.
// Synchronous active-low aresetn clears phase, overflow count, edge times and output valid,
// and sets xtal_mhz to 8 and timer_prescaler to 1.
module pulse_period_duty_meter #(
    parameter int TIMER_BITS    = ppdm_pkg::TIMER_BITS_DEF,
    parameter int OVERFLOW_BITS = ppdm_pkg::OVERFLOW_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input transactions
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_operation,
    input  logic [TIMER_BITS-1:0]           s_captured_count,
    // result transactions
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ppdm_pkg::FREQ_W-1:0]     m_frequency_hz,
    output logic [ppdm_pkg::DUTY_W-1:0]     m_duty_percent,
    output logic                            m_zero_period,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppdm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ppdm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ppdm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import ppdm_pkg::*;

    logic [XTAL_W-1:0] xtal_reg;
    logic [PRE_W-1:0]  pre_reg;
    logic              reg_sel;
    logic              cfg_wr;
    logic              accept;
    logic              need_calc;
    logic              out_free;
    ppdm_cmd_t         cmd;
    logic [FREQ_W-1:0] dp_freq;
    logic [DUTY_W-1:0] dp_duty;
    logic              dp_zero;
    logic              m_valid_reg;
    logic [FREQ_W-1:0] m_freq_reg;
    logic [DUTY_W-1:0] m_duty_reg;
    logic              m_zero_reg;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_ADDR_W-1];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xtal_reg <= XTAL_RESET;
            pre_reg  <= PRE_RESET;
        end else if (cfg_wr) begin
            if (reg_sel == REG_XTAL) begin
                xtal_reg <= pwdata[XTAL_W-1:0];
            end else begin
                pre_reg <= pwdata[PRE_W-1:0];
            end
        end
    end

    assign prdata = (reg_sel == REG_PRESCALER) ? APB_DATA_W'(pre_reg) : APB_DATA_W'(xtal_reg);

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    ppdm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .need_calc (need_calc),
        .out_free  (out_free),
        .in_ready  (s_ready),
        .cmd       (cmd)
    );

    ppdm_dp #(
        .TIMER_BITS    (TIMER_BITS),
        .OVERFLOW_BITS (OVERFLOW_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .operation       (s_operation),
        .captured_count  (s_captured_count),
        .xtal_mhz        (xtal_reg),
        .timer_prescaler (pre_reg),
        .cmd             (cmd),
        .need_calc       (need_calc),
        .frequency_hz    (dp_freq),
        .duty_percent    (dp_duty),
        .zero_period     (dp_zero)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_freq_reg <= dp_freq;
            m_duty_reg <= dp_duty;
            m_zero_reg <= dp_zero;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_frequency_hz = m_freq_reg;
    assign m_duty_percent = m_duty_reg;
    assign m_zero_period  = m_zero_reg;

endmodule

// ----- sv/ppdm_checker.sv -----
// port-level checks of the pulse meter, bound to the top level
`include "pulse_period_duty_meter_macros.svh"

module ppdm_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [ppdm_pkg::FREQ_W-1:0] m_frequency_hz,
    input logic [ppdm_pkg::DUTY_W-1:0] m_duty_percent,
    input logic                        m_zero_period
);
    import ppdm_pkg::*;

    logic                     in_acc;
    logic                     out_stall;
    logic [FREQ_W+DUTY_W:0]   m_payload;
    logic                     zero_out;
    logic                     zero_res;
    logic                     duty_ok;

    // helper terms for the checks below
    assign in_acc    = s_valid && s_ready;
    assign out_stall = m_valid && !m_ready;
    assign m_payload = {m_frequency_hz, m_duty_percent, m_zero_period};
    assign zero_out  = m_valid && m_zero_period;
    assign zero_res  = (m_frequency_hz == '0) && (m_duty_percent == '0);
    assign duty_ok   = (m_duty_percent <= PERCENT_FULL);

    // a stalled result stays valid
    `PPDM_ASSERT_NXT(a_keep, aclk, aresetn, out_stall, m_valid, "result dropped while stalled")

    // a stalled result holds its payload
    `PPDM_ASSERT_NXT(a_hold, aclk, aresetn, out_stall, $stable(m_payload), "stalled result changed")

    // zero period forces zero frequency and duty
    `PPDM_ASSERT_IMP(a_zero_out, aclk, aresetn, zero_out, zero_res, "nonzero result at zero")

    // duty never exceeds full scale
    `PPDM_ASSERT_IMP(a_duty_max, aclk, aresetn, m_valid, duty_ok, "duty above 100 percent")

    // a new result never appears right after an input transaction
    `PPDM_ASSERT_IMP(a_no_fast, aclk, aresetn, $rose(m_valid), !$past(in_acc), "result after input")

endmodule

bind pulse_period_duty_meter ppdm_checker u_ppdm_checker (.*);

// ----- test/tb_pulse_period_duty_meter.sv -----
// testbench of the pulse period and duty meter: scoreboard predictor, directed and random stimulus
`timescale 1ns / 100ps

module tb_pulse_period_duty_meter;
    import ppdm_pkg::*;

    localparam int TB_TIMER_BITS   = TIMER_BITS_DEF;
    localparam int TB_OVF_BITS     = OVERFLOW_BITS_DEF;
    localparam int SPAN_W          = TIMER_BITS_DEF + OVERFLOW_BITS_DEF;
    localparam int DRAIN_CYCLES    = 60;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_COUNT     = 8;
    localparam int PHASE_ITEMS     = 235;

    localparam logic [APB_ADDR_W-1:0] ADDR_XTAL      = APB_ADDR_W'(4 * REG_XTAL);
    localparam logic [APB_ADDR_W-1:0] ADDR_PRESCALER = APB_ADDR_W'(4 * REG_PRESCALER);

    // where the meter stands in its rise, fall, rise sequence
    typedef enum logic [1:0] {
        AWAIT_RISE      = 2'd0,
        AWAIT_FALL      = 2'd1,
        AWAIT_NEXT_RISE = 2'd2
    } capture_phase_e;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency_hz;
        logic [DUTY_W-1:0] duty_percent;
        logic              zero_period;
    } meter_result_t;

    // tracks the meter state and holds the measurements still to come out
    class meter_scoreboard;
        logic [XTAL_W-1:0]        xtal_mhz;
        logic [PRE_W-1:0]         prescaler;
        capture_phase_e           phase;
        logic [TB_OVF_BITS-1:0]   ovf_count;
        logic [TB_TIMER_BITS-1:0] first_edge;
        logic [SPAN_W-1:0]        falling_edge;
        meter_result_t            measurement_q[$];
        int unsigned              mismatches;

        function new();
            xtal_mhz     = XTAL_RESET;
            prescaler    = PRE_RESET;
            phase        = AWAIT_RISE;
            ovf_count    = '0;
            first_edge   = '0;
            falling_edge = '0;
            mismatches   = 0;
        endfunction

        function void set_register(logic idx, logic [APB_DATA_W-1:0] value);
            if (idx == REG_XTAL)
                xtal_mhz = value[XTAL_W-1:0];
            else
                prescaler = value[PRE_W-1:0];
        endfunction

        // update the state for one accepted input transaction
        function void note_input(logic op, logic [TB_TIMER_BITS-1:0] count);
            logic [SPAN_W-1:0] stamp;
            logic [SPAN_W-1:0] period;
            logic [SPAN_W-1:0] high_time;
            logic [63:0]       pre;
            logic [63:0]       freq;
            logic [63:0]       duty;
            meter_result_t     res;
            stamp = {ovf_count, count};
            if (op == OP_OVERFLOW) begin
                ovf_count = ovf_count + 1'b1;
                return;
            end
            case (phase)
                AWAIT_FALL: begin
                    falling_edge = stamp;
                    phase = AWAIT_NEXT_RISE;
                end
                AWAIT_NEXT_RISE: begin
                    period    = stamp - SPAN_W'(first_edge);
                    high_time = falling_edge - SPAN_W'(first_edge);
                    phase     = AWAIT_RISE;
                    res       = '0;
                    if (period == '0) begin
                        res.zero_period = 1'b1;
                    end else begin
                        // a prescaler of zero divides by one
                        pre  = (prescaler == '0) ? 64'd1 : 64'(prescaler);
                        freq = (64'(xtal_mhz) * 64'(HZ_PER_MHZ)) /
                               ((64'd1 << CLOCKS_SHIFT) * pre * 64'(period));
                        if (freq > 64'(FREQ_MAX))
                            freq = 64'(FREQ_MAX);
                        duty = (64'(high_time) * 64'(PERCENT_FULL)) / 64'(period);
                        if (duty > 64'(PERCENT_FULL))
                            duty = 64'(PERCENT_FULL);
                        res.frequency_hz = freq[FREQ_W-1:0];
                        res.duty_percent = duty[DUTY_W-1:0];
                    end
                    measurement_q.push_back(res);
                end
                default: begin
                    ovf_count  = '0;
                    first_edge = count;
                    phase      = AWAIT_FALL;
                end
            endcase
        endfunction

        // compare one accepted result transaction with the oldest measurement
        function void check_result(meter_result_t got);
            meter_result_t want;
            if (measurement_q.size() == 0) begin
                $error("unexpected result: frequency_hz %0d duty_percent %0d zero_period %0d",
                       got.frequency_hz, got.duty_percent, got.zero_period);
                mismatches++;
                return;
            end
            want = measurement_q.pop_front();
            if (got.frequency_hz !== want.frequency_hz) begin
                $error("frequency_hz: expected %0d, actual %0d",
                       want.frequency_hz, got.frequency_hz);
                mismatches++;
            end
            if (got.duty_percent !== want.duty_percent) begin
                $error("duty_percent: expected %0d, actual %0d",
                       want.duty_percent, got.duty_percent);
                mismatches++;
            end
            if (got.zero_period !== want.zero_period) begin
                $error("zero_period: expected %0d, actual %0d",
                       want.zero_period, got.zero_period);
                mismatches++;
            end
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_operation;
    logic [TB_TIMER_BITS-1:0] s_captured_count;
    logic                     m_valid;
    logic                     m_ready;
    logic [FREQ_W-1:0]        m_frequency_hz;
    logic [DUTY_W-1:0]        m_duty_percent;
    logic                     m_zero_period;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0]    pwdata;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;

    meter_scoreboard sb;
    int unsigned     send_idle_pct;
    int unsigned     recv_stall_pct;
    int unsigned     hold_left;

    pulse_period_duty_meter u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_captured_count (s_captured_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frequency_hz   (m_frequency_hz),
        .m_duty_percent   (m_duty_percent),
        .m_zero_period    (m_zero_period),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result receiver, with a long hold-off when requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : result_monitor
        meter_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.frequency_hz = m_frequency_hz;
            got.duty_percent = m_duty_percent;
            got.zero_period  = m_zero_period;
            sb.check_result(got);
        end
    end

    // register write over the configuration port, starts and ends at a falling edge
    task automatic write_register(input logic idx, input logic [APB_DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = (idx == REG_XTAL) ? ADDR_XTAL : ADDR_PRESCALER;
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_register(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // offer one input transaction, with random idle ahead of it
    task automatic send_item(input logic op, input logic [TB_TIMER_BITS-1:0] count);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid          = 1'b1;
        s_operation      = op;
        s_captured_count = count;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(op, count);
        @(negedge aclk);
    endtask

    // sender pauses until every measurement has come out
    task automatic wait_measurements();
        s_valid = 1'b0;
        while (sb.measurement_q.size() != 0)
            @(negedge aclk);
    endtask

    // block idle: no measurement pending and no computation left in flight
    task automatic wait_idle();
        wait_measurements();
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic send_overflows(output int n);
        int unsigned r;
        r = $urandom_range(399);
        if (r < 200)
            n = 0;
        else if (r < 360)
            n = $urandom_range(1, 3);
        else if (r < 398)
            n = $urandom_range(4, 20);
        else
            n = $urandom_range(250, 300);  // usually enough to wrap the overflow count
        repeat (n) send_item(OP_OVERFLOW, TB_TIMER_BITS'($urandom));
    endtask

    // next edge time: near the first edge, equal to it, or anywhere
    function automatic logic [TB_TIMER_BITS-1:0] pick_edge(logic [TB_TIMER_BITS-1:0] first);
        case ($urandom_range(5))
            0:       return first;
            1, 2:    return first + TB_TIMER_BITS'($urandom_range(1, 3000));
            3:       return first - TB_TIMER_BITS'($urandom_range(1, 50));
            default: return TB_TIMER_BITS'($urandom);
        endcase
    endfunction

    // mostly complete rise, fall, rise sequences, the rest single noise transactions
    task automatic run_random(input int n_items, input bit pause_midway);
        int                       sent;
        int                       n;
        bit                       paused;
        logic [TB_TIMER_BITS-1:0] first;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            if (pause_midway && !paused && sent >= n_items / 2) begin
                wait_measurements();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 85) begin
                first = TB_TIMER_BITS'($urandom);
                send_item(OP_CAPTURE, first);
                send_overflows(n);
                sent += n + 1;
                send_item(OP_CAPTURE, pick_edge(first));
                send_overflows(n);
                sent += n + 1;
                send_item(OP_CAPTURE, pick_edge(first));
                sent++;
            end else begin
                send_item(1'($urandom_range(1)), TB_TIMER_BITS'($urandom));
                sent++;
            end
        end
    endtask

    task automatic run_directed();
        // overflows before the first edge are cleared by it
        send_item(OP_OVERFLOW, 16'hFFFF);
        send_item(OP_OVERFLOW, 16'h0000);
        // widest period from one timer wrap, high time just under it
        send_item(OP_CAPTURE, 16'h0000);
        send_item(OP_CAPTURE, 16'hFFFF);
        send_item(OP_OVERFLOW, 16'h5A5A);
        send_item(OP_CAPTURE, 16'h0000);
        // zero period
        send_item(OP_CAPTURE, 16'h1234);
        send_item(OP_CAPTURE, 16'h1234);
        send_item(OP_CAPTURE, 16'h1234);
        // reversed edges wrap around the extended span
        send_item(OP_CAPTURE, 16'hFFFF);
        send_item(OP_CAPTURE, 16'h0000);
        send_item(OP_CAPTURE, 16'h0001);
        // falling edge after the period: duty clamped
        send_item(OP_CAPTURE, 16'd100);
        send_item(OP_CAPTURE, 16'd500);
        send_item(OP_CAPTURE, 16'd200);
        wait_idle();
        // crystal above range with a zero prescaler: frequency saturates
        write_register(REG_XTAL, 32'd127);
        write_register(REG_PRESCALER, 32'd0);
        send_item(OP_CAPTURE, 16'd5);
        send_item(OP_CAPTURE, 16'd5);
        send_item(OP_CAPTURE, 16'd6);
        // one-tick period with full high time
        send_item(OP_CAPTURE, 16'd0);
        send_item(OP_CAPTURE, 16'd1);
        send_item(OP_CAPTURE, 16'd1);
        wait_idle();
    endtask

    // run limit
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // main sequence
    initial begin
        logic [XTAL_W-1:0] xtal_tab [PHASE_COUNT];
        logic [PRE_W-1:0]  pre_tab  [PHASE_COUNT];
        xtal_tab = '{7'd8, 7'd1, 7'd64, 7'd127, 7'd1, 7'd64, 7'd0, 7'd0};
        pre_tab  = '{4'd1, 4'd8, 4'd1, 4'd15, 4'd0, 4'd8, 4'd0, 4'd0};
        sb               = new();
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_operation      = OP_OVERFLOW;
        s_captured_count = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_left        = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        run_directed();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            // last two phases take random in-range settings
            if (p >= PHASE_COUNT - 2) begin
                xtal_tab[p] = XTAL_W'($urandom_range(1, 64));
                pre_tab[p]  = PRE_W'($urandom_range(1, 8));
            end
            write_register(REG_XTAL, APB_DATA_W'(xtal_tab[p]));
            write_register(REG_PRESCALER, APB_DATA_W'(pre_tab[p]));
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (p == 0)
                hold_left = HOLD_OFF_CYCLES;
            run_random(PHASE_ITEMS, p == 1);
            wait_idle();
        end

        if (sb.mismatches == 0 && sb.measurement_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
